[rtl/core/sqmm_pkg.sv]
// ----------------------------------------------------------------------------
// sqmm_pkg: shared definitions of the square matrix multiplier
// Field widths, register map, reset values and the types that pass
// between the loader, the job queue and the compute engine.
// ----------------------------------------------------------------------------
package sqmm_pkg;

  localparam int DEF_MAX_DIM = 8;

  localparam int ELEM_W    = 16;
  localparam int MUL_W     = 2 * ELEM_W;
  localparam int PROD_W    = 40;
  localparam int DIM_REG_W = 4;
  localparam int APB_W     = 32;
  localparam int PADDR_W   = 1;

  localparam logic [DIM_REG_W-1:0] DIM_RESET      = 4'd8;
  localparam logic [PADDR_W-1:0]   ADDR_DIMENSION = 1'b0;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

  // Store write request from the loader.
  typedef struct packed {
    logic                     en;
    logic                     to_b;
    logic signed [ELEM_W-1:0] data;
  } elem_wr_t;

endpackage

[rtl/core/square_matrix_multiply_top.sv]
// ----------------------------------------------------------------------------
// square_matrix_multiply_top: signed square matrix multiplier
// Loads A then B row-major, one element per beat, and returns C = A * B
// row-major as full-width 40-bit sums, flagging the final element.
// ----------------------------------------------------------------------------
// Usage:
// The dimension register (byte address 0 of the APB-style port, reset 8)
// sets n; zero acts as one and values above MAX_DIM saturate. Writing it
// restarts the load with A. Write it only while the block is idle.
// An element beat is taken on a clock edge with start high and busy low.
// The first n*n beats fill A, the next n*n fill B, one beat per cycle.
// The beat that completes B posts a job to a two-entry queue. From the
// next cycle busy is high while the job is queued and while the engine
// performs one multiply-accumulate per cycle; its single multiplier and
// the one read port of each store set that rate.
// Results appear on product_element with result_valid high for exactly one
// cycle each; last_element marks the final element of C. The receiver
// cannot stall the block, so results must be taken as they come. The
// stores need no clearing: reset returns the loader to the start of A,
// empties the queue, sets the dimension to 8 and idles the engine, so
// the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module square_matrix_multiply_top #(
  parameter int MAX_DIM = sqmm_pkg::DEF_MAX_DIM
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sqmm_pkg::PADDR_W-1:0]        paddr,
  input  logic [sqmm_pkg::APB_W-1:0]          pwdata,
  output logic [sqmm_pkg::APB_W-1:0]          prdata,
  output logic                                pready,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [sqmm_pkg::ELEM_W-1:0]  element_value,
  output logic                                result_valid,
  output logic signed [sqmm_pkg::PROD_W-1:0]  product_element,
  output logic                                last_element
);
  import sqmm_pkg::*;

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;

  logic [DIM_REG_W-1:0] dimension;
  logic                 cfg_write;
  logic                 dim_write;
  logic                 accept;

  elem_wr_t         wr;
  logic [IDX_W-1:0] wr_addr;
  logic             job_push;
  logic [DIM_W-1:0] job_dim;
  logic             job_pop;
  logic             job_empty;
  logic [DIM_W-1:0] job_head;
  logic             running;

  // Configuration port: zero wait states, one register.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign dim_write = cfg_write && (paddr == ADDR_DIMENSION);

  always_ff @(posedge clk) begin
    if (rst) begin
      dimension <= DIM_RESET;
    end else if (dim_write) begin
      dimension <= pwdata[DIM_REG_W-1:0];
    end
  end

  always_comb begin
    if (paddr == ADDR_DIMENSION) begin
      prdata = {(APB_W - DIM_REG_W)'(0), dimension};
    end else begin
      prdata = '0;
    end
  end

  // The block holds off new elements while a job is queued or running,
  // since the engine reads the same stores the loader writes.
  assign busy   = !job_empty || running;
  assign accept = start && !busy;

  sqmm_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_clear     (dim_write),
    .dimension     (dimension),
    .accept        (accept),
    .element_value (element_value),
    .wr            (wr),
    .wr_addr       (wr_addr),
    .job_push      (job_push),
    .job_dim       (job_dim)
  );

  sqmm_job_fifo #(
    .W (DIM_W)
  ) u_job_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_data (job_dim),
    .pop       (job_pop),
    .empty     (job_empty),
    .head      (job_head)
  );

  sqmm_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .wr              (wr),
    .wr_addr         (wr_addr),
    .job_valid       (!job_empty),
    .job_dim         (job_head),
    .job_pop         (job_pop),
    .running         (running),
    .result_valid    (result_valid),
    .product_element (product_element),
    .last_element    (last_element)
  );

endmodule

[rtl/core/sqmm_front.sv]
// ----------------------------------------------------------------------------
// sqmm_front: element loader
// Counts incoming elements into the A and B stores and posts a job with
// the effective dimension once the last element of B is in.
// ----------------------------------------------------------------------------
module sqmm_front #(
  parameter int MAX_DIM = sqmm_pkg::DEF_MAX_DIM,
  localparam int DIM_W = $clog2(MAX_DIM + 1),
  localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_clear,
  input  logic [sqmm_pkg::DIM_REG_W-1:0]      dimension,
  input  logic                                accept,
  input  logic signed [sqmm_pkg::ELEM_W-1:0]  element_value,
  output sqmm_pkg::elem_wr_t                  wr,
  output logic [IDX_W-1:0]                    wr_addr,
  output logic                                job_push,
  output logic [DIM_W-1:0]                    job_dim
);
  import sqmm_pkg::*;

  localparam int NN_W = 2 * DIM_W;

  logic             phase;
  logic             phase_next;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_next;
  logic [DIM_W-1:0] n_eff;
  logic [NN_W-1:0]  nn;
  logic             at_last;

  // A zero dimension acts as one; anything above the store size saturates.
  always_comb begin
    priority if (dimension == '0) begin
      n_eff = DIM_W'(1);
    end else if (32'(dimension) > 32'(MAX_DIM)) begin
      n_eff = DIM_W'(MAX_DIM);
    end else begin
      n_eff = DIM_W'(dimension);
    end
  end

  assign nn      = NN_W'(n_eff) * NN_W'(n_eff);
  assign at_last = (NN_W'(idx) == NN_W'(nn - 1'b1));

  always_comb begin
    if (at_last) begin
      idx_next   = '0;
      phase_next = ~phase;
    end else begin
      idx_next   = IDX_W'(idx + 1'b1);
      phase_next = phase;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_clear) begin
      idx   <= '0;
      phase <= 1'b0;
    end else if (accept) begin
      idx   <= idx_next;
      phase <= phase_next;
    end
  end

  assign wr.en    = accept;
  assign wr.to_b  = phase;
  assign wr.data  = element_value;
  assign wr_addr  = idx;
  assign job_push = accept && phase && at_last;
  assign job_dim  = n_eff;

  a_idx_in_matrix: assert property (@(posedge clk) disable iff (rst)
    accept |-> (NN_W'(idx) < nn))
    else $error("load index beyond matrix size");

endmodule

[rtl/core/sqmm_job_fifo.sv]
// ----------------------------------------------------------------------------
// sqmm_job_fifo: two-entry job queue
// Holds posted multiply jobs between the loader and the compute engine.
// ----------------------------------------------------------------------------
module sqmm_job_fifo #(
  parameter int W = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] head
);
  import sqmm_pkg::*;

  localparam int DEPTH = 2;

  logic [W-1:0] entries [DEPTH];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= 2'(count + {1'b0, push} - {1'b0, pop});
    end
  end

  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != 2'(DEPTH) || pop))
    else $error("job queue overflow");

endmodule

[rtl/core/sqmm_back.sv]
// ----------------------------------------------------------------------------
// sqmm_back: compute engine
// Holds the A and B stores and runs one multiply-accumulate per cycle
// through read, multiply and accumulate stages, emitting C row-major.
// ----------------------------------------------------------------------------
module sqmm_back #(
  parameter int MAX_DIM = sqmm_pkg::DEF_MAX_DIM,
  localparam int DIM_W = $clog2(MAX_DIM + 1),
  localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  sqmm_pkg::elem_wr_t                  wr,
  input  logic [IDX_W-1:0]                    wr_addr,
  input  logic                                job_valid,
  input  logic [DIM_W-1:0]                    job_dim,
  output logic                                job_pop,
  output logic                                running,
  output logic                                result_valid,
  output logic signed [sqmm_pkg::PROD_W-1:0]  product_element,
  output logic                                last_element
);
  import sqmm_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;

  logic signed [ELEM_W-1:0] mem_a [DEPTH];
  logic signed [ELEM_W-1:0] mem_b [DEPTH];

  back_state_t state;
  back_state_t state_next;

  logic [DIM_W-1:0] n_reg;
  logic [DIM_W-1:0] i_cnt;
  logic [DIM_W-1:0] j_cnt;
  logic [DIM_W-1:0] k_cnt;
  logic [IDX_W-1:0] row_base;
  logic [IDX_W-1:0] a_addr;
  logic [IDX_W-1:0] b_addr;
  logic             issue;
  logic             k_last;
  logic             j_last;
  logic             i_last;

  logic                     s1_valid, s1_first, s1_last, s1_final;
  logic signed [ELEM_W-1:0] rd_a;
  logic signed [ELEM_W-1:0] rd_b;
  logic                     s2_valid, s2_first, s2_last, s2_final;
  logic signed [MUL_W-1:0]  prod;
  logic signed [PROD_W-1:0] prod_ext;
  logic signed [PROD_W-1:0] acc;
  logic signed [PROD_W-1:0] sum_now;

  assign k_last = (k_cnt == DIM_W'(n_reg - 1'b1));
  assign j_last = (j_cnt == DIM_W'(n_reg - 1'b1));
  assign i_last = (i_cnt == DIM_W'(n_reg - 1'b1));

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (job_valid) begin
          state_next = BK_RUN;
        end
      end
      BK_RUN: begin
        if (k_last && j_last && i_last) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    job_pop = 1'b0;
    issue   = 1'b0;
    unique case (state)
      BK_IDLE: job_pop = job_valid;
      BK_RUN:  issue   = 1'b1;
      default: begin
        job_pop = 1'b0;
        issue   = 1'b0;
      end
    endcase
  end

  assign running = issue;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Walk i, j, k with running addresses: A steps by one, B steps by a row.
  always_ff @(posedge clk) begin
    if (job_pop) begin
      n_reg    <= job_dim;
      i_cnt    <= '0;
      j_cnt    <= '0;
      k_cnt    <= '0;
      row_base <= '0;
      a_addr   <= '0;
      b_addr   <= '0;
    end else if (issue) begin
      if (!k_last) begin
        k_cnt  <= DIM_W'(k_cnt + 1'b1);
        a_addr <= IDX_W'(a_addr + 1'b1);
        b_addr <= IDX_W'(b_addr + IDX_W'(n_reg));
      end else begin
        k_cnt <= '0;
        if (!j_last) begin
          j_cnt  <= DIM_W'(j_cnt + 1'b1);
          a_addr <= row_base;
          b_addr <= IDX_W'(IDX_W'(j_cnt) + 1'b1);
        end else begin
          j_cnt    <= '0;
          b_addr   <= '0;
          i_cnt    <= DIM_W'(i_cnt + 1'b1);
          row_base <= IDX_W'(row_base + IDX_W'(n_reg));
          a_addr   <= IDX_W'(row_base + IDX_W'(n_reg));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && !wr.to_b) begin
      mem_a[wr_addr] <= wr.data;
    end
    if (issue) begin
      rd_a <= mem_a[a_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr.to_b) begin
      mem_b[wr_addr] <= wr.data;
    end
    if (issue) begin
      rd_b <= mem_b[b_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      s1_valid     <= issue;
      s2_valid     <= s1_valid;
      result_valid <= s2_valid && s2_last;
    end
  end

  always_ff @(posedge clk) begin
    s1_first <= (k_cnt == '0);
    s1_last  <= k_last;
    s1_final <= k_last && j_last && i_last;
    s2_first <= s1_first;
    s2_last  <= s1_last;
    s2_final <= s1_final;
    prod     <= rd_a * rd_b;
  end

  assign prod_ext = {{(PROD_W - MUL_W){prod[MUL_W-1]}}, prod};
  assign sum_now  = (s2_first ? PROD_W'(0) : acc) + prod_ext;

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      acc <= sum_now;
    end
    if (s2_valid && s2_last) begin
      product_element <= sum_now;
      last_element    <= s2_final;
    end
  end

  a_counters_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == BK_RUN) |-> (k_cnt < n_reg && j_cnt < n_reg && i_cnt < n_reg))
    else $error("loop counter beyond dimension");

  a_read_only_when_running: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> $past(state == BK_RUN))
    else $error("store read outside a job");

  a_final_ends_burst: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last_element) |=> !result_valid)
    else $error("result directly after the final element");

endmodule
